/* rtl/mdfb_pkg.sv */
`default_nettype none

package mdfb_pkg;

	// Action codes carried on the action field.
	localparam logic [2:0] ACT_POINT   = 3'd0;
	localparam logic [2:0] ACT_FILL    = 3'd1;
	localparam logic [2:0] ACT_WRITE   = 3'd2;
	localparam logic [2:0] ACT_CLEAR   = 3'd3;
	localparam logic [2:0] ACT_REFRESH = 3'd4;
	localparam logic [2:0] ACT_READ    = 3'd5;

	// Panel stream command bytes sent ahead of every page.
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		logic       load;
		logic [7:0] out_byte;
		logic       is_data;
		logic       is_link_byte;
		logic       frame_done;
	} result_t;

endpackage

`default_nettype wire

/* rtl/mono_display_framebuffer_top.sv */
// Page-organized monochrome frame store for a COLUMNS x (8*PAGES) panel with a
// refresh stream generator. Each store byte holds eight stacked pixels of one
// column with rows flipped vertically. Every accepted transfer yields exactly
// one result transfer. Point, byte read and refresh tick read the frame memory
// when the item is accepted; point and byte write write back on a hit, and every
// result is handed on, in the wait state once the output register is free. A
// rectangle fill reads and then writes back every store byte it touches. A clear
// writes every store byte, one memory write per cycle. After reset the block
// clears the whole store and holds item_stall high until that pass is done. A
// finished result waits in the output register while the next item is already
// being taken.
`default_nettype none

module mono_display_framebuffer_top #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [2:0] action,
	input  wire logic [6:0] column,
	input  wire logic [5:0] row,
	input  wire logic [6:0] column_end,
	input  wire logic [5:0] row_end,
	input  wire logic [2:0] page,
	input  wire logic [7:0] data_byte,
	input  wire logic       pixel_on,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      out_byte,
	output logic            is_data,
	output logic            is_link_byte,
	output logic            frame_done
);

	import mdfb_pkg::*;

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);

	result_t       res;
	logic          out_free;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       is_link_byte_q;
	logic       frame_done_q;

	// The output register can take a new result when it is empty or when its
	// current result leaves in this cycle.
	assign out_free = !out_valid_q || !result_stall;

	mdfb_ctrl #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action    (action),
		.column    (column),
		.row       (row),
		.column_end(column_end),
		.row_end   (row_end),
		.page      (page),
		.data_byte (data_byte),
		.pixel_on  (pixel_on),
		.out_free  (out_free),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	mdfb_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Output register: holds a result until the downstream side takes the
	// transfer, so the sequencer can move on to the next item meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			out_byte_q     <= '0;
			is_data_q      <= 1'b0;
			is_link_byte_q <= 1'b0;
			frame_done_q   <= 1'b0;
		end else begin
			if (res.load) begin
				out_valid_q    <= 1'b1;
				out_byte_q     <= res.out_byte;
				is_data_q      <= res.is_data;
				is_link_byte_q <= res.is_link_byte;
				frame_done_q   <= res.frame_done;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign is_data      = is_data_q;
	assign is_link_byte = is_link_byte_q;
	assign frame_done   = frame_done_q;

endmodule

`default_nettype wire

/* rtl/mdfb_store.sv */
`default_nettype none

module mdfb_store #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// The read register holds its value until the next read is issued.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/mdfb_ctrl.sv */
`default_nettype none

module mdfb_ctrl #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [2:0]                       action,
	input  wire logic [6:0]                       column,
	input  wire logic [5:0]                       row,
	input  wire logic [6:0]                       column_end,
	input  wire logic [5:0]                       row_end,
	input  wire logic [2:0]                       page,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             pixel_on,
	input  wire logic                             out_free,
	output mdfb_pkg::result_t                     res,
	output logic                                  rd_en,
	output logic [$clog2(COLUMNS*PAGES)-1:0]      rd_addr,
	input  wire logic [7:0]                       rd_data,
	output logic                                  wr_en,
	output logic [$clog2(COLUMNS*PAGES)-1:0]      wr_addr,
	output logic [7:0]                            wr_data
);

	import mdfb_pkg::*;

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int POSW  = $clog2(COLUMNS + 3);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_WAIT
	} state_t;

	state_t          state_q;
	logic [2:0]      act_q;
	logic [AW-1:0]   addr_q;
	logic [7:0]      mask_q;
	logic            on_q;
	logic [7:0]      data_q;
	logic            hit_q;
	logic [7:0]      byte_q;
	logic            is_data_q;
	logic            link_q;
	logic            done_q;
	logic            use_mem_q;
	logic [6:0]      x_q;
	logic [6:0]      x_last_q;
	logic [2:0]      band_q;
	logic [2:0]      band_last_q;
	logic [5:0]      row_q;
	logic [5:0]      row_end_q;
	logic [PW-1:0]   rpage_q;
	logic [POSW-1:0] rpos_q;

	function automatic logic [AW-1:0] addr_of(input logic [7:0] col, input logic [3:0] pg);
		return AW'(int'(col) * PAGES + int'(pg));
	endfunction

	logic          acc;
	logic [2:0]    band_in;
	logic          pt_hit;
	logic          by_hit;
	logic          fill_ok;
	logic [AW-1:0] pt_addr;
	logic [AW-1:0] by_addr;
	logic [AW-1:0] ref_addr;
	logic [AW-1:0] fill_addr;
	logic [7:0]    ref_col;
	logic          ref_last;
	logic [2:0]    lo;
	logic [2:0]    hi;
	logic [7:0]    fill_mask;

	logic          dec_hit;
	logic          dec_use_mem;
	logic [7:0]    dec_byte;
	logic          dec_is_data;
	logic          dec_link;
	logic          dec_done;
	state_t        dec_state;

	assign acc        = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);

	assign band_in  = row[5:3];
	assign pt_hit   = (int'(column) < COLUMNS) && (int'(band_in) < PAGES);
	assign by_hit   = (int'(column) < COLUMNS) && (int'(page) < PAGES);
	assign fill_ok  = (column <= column_end) && (row <= row_end) && pt_hit;
	assign pt_addr  = addr_of({1'b0, column}, 4'(PAGES - 1 - int'(band_in)));
	assign by_addr  = addr_of({1'b0, column}, {1'b0, page});
	assign ref_col  = 8'(rpos_q - POSW'(3));
	assign ref_addr = addr_of(ref_col, 4'(rpage_q));
	assign ref_last = (rpos_q == POSW'(COLUMNS + 2));
	assign fill_addr = addr_of({1'b0, x_q}, 4'(PAGES - 1 - int'(band_q)));

	// Rows covered inside the current band: bit 7-r stands for row r of the band.
	assign lo        = (band_q == row_q[5:3]) ? row_q[2:0] : 3'd0;
	assign hi        = (band_q == row_end_q[5:3]) ? row_end_q[2:0] : 3'd7;
	assign fill_mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));

	// Decode of the item being accepted: result fields and the next state.
	always_comb begin
		dec_hit     = 1'b0;
		dec_use_mem = 1'b0;
		dec_byte    = 8'h00;
		dec_is_data = 1'b0;
		dec_link    = 1'b0;
		dec_done    = 1'b0;
		dec_state   = ST_WAIT;
		case (action)
			ACT_POINT: dec_hit = pt_hit;
			ACT_WRITE: dec_hit = by_hit;
			ACT_READ:  dec_use_mem = by_hit;
			ACT_CLEAR: dec_state = ST_CLR;
			ACT_FILL: begin
				if (fill_ok) begin
					dec_state = ST_FILL_RD;
				end
			end
			ACT_REFRESH: begin
				dec_link = 1'b1;
				if (rpos_q == POSW'(0)) begin
					dec_byte = CMD_PAGE_BASE + 8'(rpage_q);
				end else if (rpos_q == POSW'(1)) begin
					dec_byte = CMD_COL_LOW;
				end else if (rpos_q == POSW'(2)) begin
					dec_byte = CMD_COL_HIGH;
				end else begin
					dec_use_mem = 1'b1;
					dec_is_data = 1'b1;
				end
				dec_done = ref_last && (rpage_q == PW'(PAGES - 1));
			end
			default: dec_hit = 1'b0;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = fill_addr;
		if (state_q == ST_FILL_RD) begin
			rd_en = 1'b1;
		end else if (acc) begin
			case (action)
				ACT_POINT: begin
					rd_en   = 1'b1;
					rd_addr = pt_addr;
				end
				ACT_READ: begin
					rd_en   = 1'b1;
					rd_addr = by_addr;
				end
				ACT_REFRESH: begin
					rd_en   = 1'b1;
					rd_addr = ref_addr;
				end
				default: rd_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = 8'h00;
		case (state_q)
			ST_INIT, ST_CLR: wr_en = 1'b1;
			ST_FILL_WR: begin
				wr_en   = 1'b1;
				wr_addr = fill_addr;
				wr_data = on_q ? (rd_data | fill_mask) : (rd_data & ~fill_mask);
			end
			ST_WAIT: begin
				if (out_free && hit_q) begin
					if (act_q == ACT_POINT) begin
						wr_en   = 1'b1;
						wr_data = on_q ? (rd_data | mask_q) : (rd_data & ~mask_q);
					end else if (act_q == ACT_WRITE) begin
						wr_en   = 1'b1;
						wr_data = data_q;
					end
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		res.load         = (state_q == ST_WAIT) && out_free;
		res.out_byte     = use_mem_q ? rd_data : byte_q;
		res.is_data      = is_data_q;
		res.is_link_byte = link_q;
		res.frame_done   = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			act_q       <= ACT_POINT;
			addr_q      <= '0;
			mask_q      <= '0;
			on_q        <= 1'b0;
			data_q      <= '0;
			hit_q       <= 1'b0;
			byte_q      <= '0;
			is_data_q   <= 1'b0;
			link_q      <= 1'b0;
			done_q      <= 1'b0;
			use_mem_q   <= 1'b0;
			x_q         <= '0;
			x_last_q    <= '0;
			band_q      <= '0;
			band_last_q <= '0;
			row_q       <= '0;
			row_end_q   <= '0;
			rpage_q     <= '0;
			rpos_q      <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						act_q     <= action;
						on_q      <= pixel_on;
						data_q    <= data_byte;
						mask_q    <= 8'h80 >> row[2:0];
						row_q     <= row;
						row_end_q <= row_end;
						byte_q    <= dec_byte;
						is_data_q <= dec_is_data;
						link_q    <= dec_link;
						done_q    <= dec_done;
						use_mem_q <= dec_use_mem;
						hit_q     <= dec_hit;
						state_q   <= dec_state;
						case (action)
							ACT_POINT: addr_q <= pt_addr;
							ACT_WRITE: addr_q <= by_addr;
							ACT_CLEAR: addr_q <= '0;
							ACT_FILL: begin
								x_q    <= column;
								band_q <= band_in;
								x_last_q <= (int'(column_end) < COLUMNS) ?
									column_end : 7'(COLUMNS - 1);
								band_last_q <= (int'(row_end[5:3]) < PAGES) ?
									row_end[5:3] : 3'(PAGES - 1);
							end
							ACT_REFRESH: begin
								if (ref_last) begin
									rpos_q <= '0;
									if (rpage_q == PW'(PAGES - 1)) begin
										rpage_q <= '0;
									end else begin
										rpage_q <= rpage_q + PW'(1);
									end
								end else begin
									rpos_q <= rpos_q + POSW'(1);
								end
							end
							default: addr_q <= addr_q;
						endcase
					end
				end
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_WAIT;
					end
				end
				ST_FILL_RD: begin
					state_q <= ST_FILL_WR;
				end
				ST_FILL_WR: begin
					if (band_q == band_last_q) begin
						band_q <= row_q[5:3];
						if (x_q == x_last_q) begin
							state_q <= ST_WAIT;
						end else begin
							x_q     <= x_q + 7'd1;
							state_q <= ST_FILL_RD;
						end
					end else begin
						band_q  <= band_q + 3'd1;
						state_q <= ST_FILL_RD;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/mdfb_checker.sv */
`default_nettype none

module mdfb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic [2:0] action,
	input wire logic [6:0] column,
	input wire logic [5:0] row,
	input wire logic [6:0] column_end,
	input wire logic [5:0] row_end,
	input wire logic [2:0] page,
	input wire logic [7:0] data_byte,
	input wire logic       pixel_on,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [7:0] out_byte,
	input wire logic       is_data,
	input wire logic       is_link_byte,
	input wire logic       frame_done
);

	// A stalled item keeps its payload.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(action) &&
		$stable(column) && $stable(row) && $stable(column_end) &&
		$stable(row_end) && $stable(page) && $stable(data_byte) && $stable(pixel_on))
		else $error("stalled item changed");

	// A stalled result keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) &&
		$stable(is_data) && $stable(is_link_byte) && $stable(frame_done))
		else $error("stalled result changed");

	// Every accepted item makes the sequencer busy, so items are never accepted back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted in back-to-back cycles");

	// Display data and frame end only appear on refresh stream bytes.
	a_data_is_link: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_data |-> is_link_byte)
		else $error("data flag without stream byte");

	// The frame ends on a display data byte.
	a_frame_done_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> is_data && is_link_byte)
		else $error("frame end on a command byte");

endmodule

bind mono_display_framebuffer_top mdfb_checker u_mdfb_checker (.*);

`default_nettype wire
